// ===== sv/voxel_brush_sculpt_paint_update_unit_defines.svh =====
// assertion macros used by the pipeline control of the voxel brush update unit
`ifndef VOXEL_BRUSH_SCULPT_PAINT_UPDATE_UNIT_DEFINES_SVH
`define VOXEL_BRUSH_SCULPT_PAINT_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VBSP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vbsp same-cycle check failed");

// next-cycle implication, checked out of reset
`define VBSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vbsp next-cycle check failed");

`endif

// ===== sv/vbsp_pkg.sv =====
// shared types and constants of the voxel brush update unit
package vbsp_pkg;

  localparam int NUM_STAGES = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] DELTA_LIMIT = 16'sd32767;
  localparam logic [7:0]         FADE_Q8     = 8'd218;
  localparam logic [7:0]         BLEND_HALF  = 8'd128;
  localparam logic [7:0]         BLEND_MAX   = 8'd255;

  typedef enum logic {
    OP_SCULPT = 1'b0,
    OP_PAINT  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCULPT_STEP    = 2'd0,
    CFG_PAINT_TEXTURE  = 2'd1,
    CFG_PAINT_STRENGTH = 2'd2
  } cfg_idx_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } stage_en_t;

endpackage

// ===== sv/vbsp_if.sv =====
// valid/ready channel interfaces for voxel items and results
interface vbsp_in_if
  import vbsp_pkg::*;
();
  logic               valid;
  logic               ready;
  op_t                operation;
  logic [11:0]        voxel_index;
  logic [8:0]         brush_weight;
  logic signed [15:0] old_delta;
  logic [15:0]        old_material;

  modport source (output valid, operation, voxel_index, brush_weight, old_delta,
                  old_material, input ready);
  modport sink (input valid, operation, voxel_index, brush_weight, old_delta,
                old_material, output ready);
endinterface

interface vbsp_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        out_index;
  logic signed [15:0] new_delta;
  logic [15:0]        new_material;

  modport source (output valid, out_index, new_delta, new_material, input ready);
  modport sink (input valid, out_index, new_delta, new_material, output ready);
endinterface

// ===== sv/vbsp_pipe_ctrl.sv =====
// valid bits and stall control of the four-stage update pipeline
`include "voxel_brush_sculpt_paint_update_unit_defines.svh"

module vbsp_pipe_ctrl
  import vbsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_en_t en
);

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] rdy;

  // a stage may load when empty or when the next one moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign en.ld     = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NUM_STAGES-1];

  `VBSP_ASSERT_IMPLY(a_full_when_blocked, !rdy[0], &v_r)
  `VBSP_ASSERT_NEXT(a_accept_fills_first, in_valid && rdy[0], v_r[0])
  `VBSP_ASSERT_NEXT(a_held_stage_keeps, v_r[1] && !rdy[2], v_r[1])
  `VBSP_ASSERT_NEXT(a_stalled_result_kept, v_r[NUM_STAGES-1] && !out_ready,
                    v_r[NUM_STAGES-1])

endmodule

// ===== sv/vbsp_sculpt.sv =====
// sculpt datapath: delta plus step times weight squared, rounded and saturated
module vbsp_sculpt
  import vbsp_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  op_t                op,
  input  logic [8:0]         wt,
  input  logic signed [15:0] old_delta,
  input  logic signed [15:0] step,
  output logic signed [15:0] new_delta
);

  // stage 1 registers
  op_t                op1_r;
  logic [17:0]        wsq1_r;
  logic [16:0]        mag1_r;
  logic               neg1_r;
  logic signed [15:0] delta1_r;
  // stage 2 registers
  op_t                op2_r;
  logic [34:0]        prod2_r;
  logic               neg2_r;
  logic signed [15:0] delta2_r;
  // stage 3 registers
  op_t                op3_r;
  logic signed [21:0] sum3_r;
  logic signed [15:0] delta3_r;
  // stage 4 register
  logic signed [15:0] nd4_r;

  logic [16:0]        stepx;
  logic [16:0]        mag1_nxt;
  logic [35:0]        rnd;
  logic [19:0]        q;
  logic signed [21:0] qs;
  logic signed [21:0] sum3_nxt;
  logic signed [15:0] nd4_nxt;

  // magnitude of the step, 32768 included
  always_comb begin
    stepx    = {step[15], step};
    mag1_nxt = step[15] ? (17'd0 - stepx) : stepx;
  end

  always_ff @(posedge clk) begin
    if (en.ld[0]) begin
      op1_r    <= op;
      wsq1_r   <= 18'(wt * wt);
      mag1_r   <= mag1_nxt;
      neg1_r   <= step[15];
      delta1_r <= old_delta;
    end
  end

  // full product of magnitude and weight squared
  always_ff @(posedge clk) begin
    if (en.ld[1]) begin
      op2_r    <= op1_r;
      prod2_r  <= 35'(mag1_r * wsq1_r);
      neg2_r   <= neg1_r;
      delta2_r <= delta1_r;
    end
  end

  // round half away from zero, apply sign, add to delta
  always_comb begin
    rnd = {1'b0, prod2_r} + 36'd32768;
    q   = rnd[35:16];
    qs  = signed'({2'b00, q});
    if (neg2_r) begin
      qs = -qs;
    end
    sum3_nxt = {{6{delta2_r[15]}}, delta2_r} + qs;
  end

  always_ff @(posedge clk) begin
    if (en.ld[2]) begin
      op3_r    <= op2_r;
      sum3_r   <= sum3_nxt;
      delta3_r <= delta2_r;
    end
  end

  // saturate, or keep the delta on paint items
  always_comb begin
    if (op3_r == OP_PAINT) begin
      nd4_nxt = delta3_r;
    end else if (sum3_r > 22'(DELTA_LIMIT)) begin
      nd4_nxt = DELTA_LIMIT;
    end else if (sum3_r < -22'(DELTA_LIMIT)) begin
      nd4_nxt = -DELTA_LIMIT;
    end else begin
      nd4_nxt = sum3_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld[3]) begin
      nd4_r <= nd4_nxt;
    end
  end

  assign new_delta = nd4_r;

endmodule

// ===== sv/vbsp_paint.sv =====
// paint datapath: slot update and blend weight push toward the painted texture
module vbsp_paint
  import vbsp_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   en,
  input  op_t         op,
  input  logic [8:0]  wt,
  input  logic [15:0] old_material,
  input  logic [3:0]  tex,
  input  logic [15:0] strength,
  output logic [15:0] new_material
);

  typedef enum logic [1:0] {
    ACT_DEC    = 2'd0,
    ACT_INC    = 2'd1,
    ACT_FILL_B = 2'd2,
    ACT_FILL_A = 2'd3
  } act_t;

  // stage 1 registers
  op_t         op1_r;
  act_t        act1_r;
  logic [16:0] p218_1_r;
  logic [24:0] pstr1_r;
  logic [15:0] mat1_r;
  logic [3:0]  tex1_r;
  // stage 2 registers
  op_t         op2_r;
  act_t        act2_r;
  logic [24:0] fprod2_r;
  logic [24:0] pstr2_r;
  logic [15:0] mat2_r;
  logic [3:0]  tex2_r;
  // stage 3 registers
  op_t         op3_r;
  logic        dec3_r;
  logic [9:0]  w3_r;
  logic [3:0]  a3_r;
  logic [3:0]  b3_r;
  logic [24:0] pstr3_r;
  logic [15:0] mat3_r;
  // stage 4 register
  logic [15:0] nm4_r;

  act_t               act1_nxt;
  logic [7:0]         fop;
  logic [7:0]         w2;
  logic [9:0]         w3_nxt;
  logic [3:0]         a3_nxt;
  logic [3:0]         b3_nxt;
  logic signed [25:0] num;
  logic signed [27:0] total;
  logic [7:0]         w4;
  logic [15:0]        nm4_nxt;

  // which slot holds the texture, or which one it replaces
  always_comb begin
    if (old_material[3:0] == tex) begin
      act1_nxt = ACT_DEC;
    end else if (old_material[7:4] == tex) begin
      act1_nxt = ACT_INC;
    end else if (old_material[15:8] < BLEND_HALF) begin
      act1_nxt = ACT_FILL_B;
    end else begin
      act1_nxt = ACT_FILL_A;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld[0]) begin
      op1_r    <= op;
      act1_r   <= act1_nxt;
      p218_1_r <= 17'(wt * FADE_Q8);
      pstr1_r  <= 25'(wt * strength);
      mat1_r   <= old_material;
      tex1_r   <= tex;
    end
  end

  // fade product: remaining or current weight times pressure times 218
  always_comb begin
    fop = (act1_r == ACT_FILL_B) ? (BLEND_MAX - mat1_r[15:8]) : mat1_r[15:8];
  end

  always_ff @(posedge clk) begin
    if (en.ld[1]) begin
      op2_r    <= op1_r;
      act2_r   <= act1_r;
      fprod2_r <= 25'(fop * p218_1_r);
      pstr2_r  <= pstr1_r;
      mat2_r   <= mat1_r;
      tex2_r   <= tex1_r;
    end
  end

  // weight after slot replacement
  always_comb begin
    w2     = mat2_r[15:8];
    a3_nxt = mat2_r[3:0];
    b3_nxt = mat2_r[7:4];
    num    = signed'({2'b00, w2, 16'd0}) - signed'({1'b0, fprod2_r});
    case (act2_r)
      ACT_FILL_B: begin
        b3_nxt = tex2_r;
        w3_nxt = {2'b00, w2} + {1'b0, fprod2_r[24:16]};
      end
      ACT_FILL_A: begin
        a3_nxt = tex2_r;
        w3_nxt = (num <= 26'sd0) ? 10'd0 : {2'b00, num[23:16]};
      end
      default: begin
        w3_nxt = {2'b00, w2};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.ld[2]) begin
      op3_r   <= op2_r;
      dec3_r  <= (act2_r == ACT_DEC) || (act2_r == ACT_FILL_A);
      w3_r    <= w3_nxt;
      a3_r    <= a3_nxt;
      b3_r    <= b3_nxt;
      pstr3_r <= pstr2_r;
      mat3_r  <= mat2_r;
    end
  end

  // add or subtract pressure times strength, clamp and repack
  always_comb begin
    if (dec3_r) begin
      total = signed'({2'b00, w3_r, 16'd0}) - signed'({3'b000, pstr3_r});
    end else begin
      total = signed'({2'b00, w3_r, 16'd0}) + signed'({3'b000, pstr3_r});
    end
    if (total[27]) begin
      w4 = 8'd0;
    end else if (total[26:16] > 11'(BLEND_MAX)) begin
      w4 = BLEND_MAX;
    end else begin
      w4 = total[23:16];
    end
    nm4_nxt = (op3_r == OP_PAINT) ? {w4, b3_r, a3_r} : mat3_r;
  end

  always_ff @(posedge clk) begin
    if (en.ld[3]) begin
      nm4_r <= nm4_nxt;
    end
  end

  assign new_material = nm4_r;

endmodule

// ===== sv/voxel_brush_sculpt_paint_update_unit.sv =====
// top level of the voxel brush sculpt and paint update unit
// Updates one voxel per transaction: sculpt items add step * weight^2 to the density
// delta (rounded half away from zero, saturated to +/-32767), paint items move the
// material blend weight toward the painted texture, replacing a slot when needed.
// The unit is a four-stage pipeline that takes one transaction every clock unless
// the result channel stalls it; the two multiplier stages (weight squared and
// pressure products, then the wide step and fade products) are followed by the two
// add/clamp stages. Backpressure on the result channel stalls only the stages that
// are full, so bubbles keep absorbing input. The user must write the configuration
// registers only while no transaction is in flight; the unit does not enforce this.
module voxel_brush_sculpt_paint_update_unit
  import vbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vbsp_in_if.sink               in_ch,
  vbsp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [15:0] sculpt_step_r;
  logic [3:0]         paint_texture_r;
  logic [15:0]        paint_strength_r;
  logic [11:0]        idx_r [NUM_STAGES];
  stage_en_t          en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sculpt_step_r    <= '0;
      paint_texture_r  <= '0;
      paint_strength_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCULPT_STEP:    sculpt_step_r    <= signed'(cfg_wdata);
        CFG_PAINT_TEXTURE:  paint_texture_r  <= cfg_wdata[3:0];
        CFG_PAINT_STRENGTH: paint_strength_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline valid and stall control
  vbsp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  // voxel index travels alongside the datapaths
  always_ff @(posedge clk) begin
    if (en.ld[0]) begin
      idx_r[0] <= in_ch.voxel_index;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en.ld[i]) begin
        idx_r[i] <= idx_r[i-1];
      end
    end
  end

  // sculpt datapath
  vbsp_sculpt u_sculpt (
    .clk       (clk),
    .en        (en),
    .op        (in_ch.operation),
    .wt        (in_ch.brush_weight),
    .old_delta (in_ch.old_delta),
    .step      (sculpt_step_r),
    .new_delta (out_ch.new_delta)
  );

  // paint datapath
  vbsp_paint u_paint (
    .clk          (clk),
    .en           (en),
    .op           (in_ch.operation),
    .wt           (in_ch.brush_weight),
    .old_material (in_ch.old_material),
    .tex          (paint_texture_r),
    .strength     (paint_strength_r),
    .new_material (out_ch.new_material)
  );

  assign out_ch.out_index = idx_r[NUM_STAGES-1];

endmodule

// ===== verif/voxel_brush_sculpt_paint_update_unit_test.sv =====
// self-checking testbench for the voxel brush sculpt and paint update unit
module voxel_brush_sculpt_paint_update_unit_test
  import vbsp_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL_AT = 700;
  localparam int LONG_STALL_CYCLES = 150;

  typedef struct packed {
    op_t                operation;
    logic [11:0]        voxel_index;
    logic [8:0]         brush_weight;
    logic signed [15:0] old_delta;
    logic [15:0]        old_material;
  } voxel_item_t;

  typedef struct packed {
    logic [11:0]        index;
    logic signed [15:0] delta;
    logic [15:0]        material;
  } voxel_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vbsp_in_if in_ch ();
  vbsp_out_if out_ch ();

  voxel_brush_sculpt_paint_update_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies used for prediction
  logic signed [15:0] step_reg;
  logic [3:0]         texture_reg;
  logic [15:0]        strength_reg;

  voxel_item_t   pending_voxels[$];
  voxel_result_t expected_updates[$];
  voxel_item_t   next_voxel;
  voxel_item_t   seen_voxel;
  voxel_result_t want_update;

  logic in_took;
  logic calm;
  logic long_stall_done;
  int   send_gap;
  int   stall_left;
  int   cycle_count;
  int   mismatches;
  int   accepted_items;
  int   sculpt_items;
  int   paint_items;
  int   results_checked;
  int   settings_used;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sculpt: step * weight^2, rounded half away from zero, saturated
  function automatic logic signed [15:0] sculpted_delta(logic signed [15:0] old,
                                                        logic [8:0] wt);
    longint step_l;
    longint mag;
    longint w;
    longint q;
    longint v;
    step_l = longint'(step_reg);
    w = longint'(wt);
    mag = (step_l < 0) ? -step_l : step_l;
    q = (mag * w * w + 32768) >> 16;
    if (step_l < 0) q = -q;
    v = longint'(old) + q;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return v[15:0];
  endfunction

  // paint: slot replacement, fade, strength push and clamp of the blend weight
  function automatic logic [15:0] painted_material(logic [15:0] packed_mat, logic [8:0] wt);
    logic [3:0] slot_a;
    logic [3:0] slot_b;
    longint w;
    longint p;
    longint sgn;
    longint num;
    longint total;
    slot_a = packed_mat[3:0];
    slot_b = packed_mat[7:4];
    w = longint'(packed_mat[15:8]);
    p = longint'(wt);
    sgn = 1;
    if (slot_a == texture_reg) begin
      sgn = -1;
    end else if (slot_b != texture_reg) begin
      if (w < 128) begin
        slot_b = texture_reg;
        w = w + (((255 - w) * p * 218) >> 16);
      end else begin
        num = w * 65536 - w * p * 218;
        slot_a = texture_reg;
        w = (num <= 0) ? 0 : (num >>> 16);
        sgn = -1;
      end
    end
    total = w * 65536 + sgn * p * longint'(strength_reg);
    if (total < 0) begin
      w = 0;
    end else begin
      w = total >>> 16;
      if (w > 255) w = 255;
    end
    return {w[7:0], slot_b, slot_a};
  endfunction

  function automatic voxel_result_t predict_update(voxel_item_t it);
    voxel_result_t r;
    r.index = it.voxel_index;
    r.delta = it.old_delta;
    r.material = it.old_material;
    if (it.operation == OP_SCULPT) r.delta = sculpted_delta(it.old_delta, it.brush_weight);
    else r.material = painted_material(it.old_material, it.brush_weight);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic void add_voxel(op_t op, logic [11:0] idx, logic [8:0] wt,
                                    logic signed [15:0] delta, logic [15:0] mat);
    voxel_item_t it;
    it.operation = op;
    it.voxel_index = idx;
    it.brush_weight = wt;
    it.old_delta = delta;
    it.old_material = mat;
    pending_voxels.push_back(it);
  endfunction

  // wait until every transaction has been sent and every result checked
  task automatic drain;
    while (pending_voxels.size() != 0 || in_ch.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SCULPT_STEP:    step_reg = value;
      CFG_PAINT_TEXTURE:  texture_reg = value[3:0];
      CFG_PAINT_STRENGTH: strength_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic signed [15:0] step, logic [3:0] tex, logic [15:0] strength);
    drain();
    write_reg(CFG_SCULPT_STEP, step);
    write_reg(CFG_PAINT_TEXTURE, {12'd0, tex});
    write_reg(CFG_PAINT_STRENGTH, strength);
    settings_used++;
  endtask

  // random voxels, biased toward slot hits and field extremes
  task automatic run_random(int count);
    logic [15:0] mat;
    logic [8:0]  wt;
    logic signed [15:0] delta;
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: wt = 9'($urandom_range(0, 256));
        6, 7:             wt = 9'($urandom_range(257, 511));
        8:                wt = 9'd256;
        default:          wt = 9'd511;
      endcase
      delta = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       delta = 16'sh7fff;
          1:       delta = 16'sh8001;
          2:       delta = 16'sh8000;
          default: delta = 16'sh0000;
        endcase
      end
      mat = 16'($urandom);
      case ($urandom_range(0, 2))
        0:       mat[3:0] = texture_reg;
        1:       mat[7:4] = texture_reg;
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       mat[15:8] = 8'd0;
          1:       mat[15:8] = 8'd127;
          2:       mat[15:8] = BLEND_HALF;
          default: mat[15:8] = BLEND_MAX;
        endcase
      end
      add_voxel(op_t'($urandom_range(0, 1)), 12'($urandom), wt, delta, mat);
    end
    drain();
  endtask

  // input driver: one transaction per item, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 19) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_voxels.size() != 0) begin
        next_voxel = pending_voxels.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= next_voxel.operation;
        in_ch.voxel_index <= next_voxel.voxel_index;
        in_ch.brush_weight <= next_voxel.brush_weight;
        in_ch.old_delta <= next_voxel.old_delta;
        in_ch.old_material <= next_voxel.old_material;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls and one long hold that backs up the pipeline
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!long_stall_done && accepted_items >= LONG_STALL_AT) begin
        stall_left = LONG_STALL_CYCLES;
        long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("result with nothing pending, index", {4'd0, out_ch.out_index}, 16'd0);
        end else begin
          want_update = expected_updates.pop_front();
          results_checked++;
          if (out_ch.out_index !== want_update.index)
            report_mismatch("out_index", {4'd0, out_ch.out_index}, {4'd0, want_update.index});
          if (out_ch.new_delta !== want_update.delta)
            report_mismatch("new_delta", out_ch.new_delta, want_update.delta);
          if (out_ch.new_material !== want_update.material)
            report_mismatch("new_material", out_ch.new_material, want_update.material);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_voxel.operation = in_ch.operation;
        seen_voxel.voxel_index = in_ch.voxel_index;
        seen_voxel.brush_weight = in_ch.brush_weight;
        seen_voxel.old_delta = in_ch.old_delta;
        seen_voxel.old_material = in_ch.old_material;
        expected_updates.push_back(predict_update(seen_voxel));
        accepted_items++;
        if (in_ch.operation == OP_SCULPT) sculpt_items++;
        else paint_items++;
      end
    end
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SCULPT_STEP;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SCULPT;
    in_ch.voxel_index = '0;
    in_ch.brush_weight = '0;
    in_ch.old_delta = '0;
    in_ch.old_material = '0;
    out_ch.ready = 1'b0;
    step_reg = '0;
    texture_reg = '0;
    strength_reg = '0;
    in_took = 1'b0;
    calm = 1'b0;
    long_stall_done = 1'b0;
    send_gap = 0;
    stall_left = 0;
    cycle_count = 0;
    mismatches = 0;
    accepted_items = 0;
    sculpt_items = 0;
    paint_items = 0;
    results_checked = 0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers at their reset values
    run_random(60);

    // directed: sculpt extremes and each paint path
    apply_settings(16'sd32767, 4'd5, 16'h0180);
    add_voxel(OP_SCULPT, 12'd0, 9'd0, 16'sd100, 16'h1234);
    add_voxel(OP_SCULPT, 12'd4095, 9'd256, 16'sd0, 16'hffff);
    add_voxel(OP_SCULPT, 12'd1, 9'd511, 16'sd32767, 16'h0000);
    add_voxel(OP_SCULPT, 12'd2, 9'd128, -16'sd32767, 16'h0000);
    add_voxel(OP_SCULPT, 12'd3, 9'd1, 16'sh8000, 16'h0000);
    add_voxel(OP_SCULPT, 12'd4, 9'd511, -16'sd32767, 16'h5a5a);
    add_voxel(OP_PAINT, 12'd5, 9'd256, 16'sd0, {8'd200, 4'd3, 4'd5});
    add_voxel(OP_PAINT, 12'd6, 9'd256, 16'sd0, {8'd10, 4'd5, 4'd2});
    add_voxel(OP_PAINT, 12'd7, 9'd256, 16'sh7fff, {8'd100, 4'd1, 4'd2});
    add_voxel(OP_PAINT, 12'd8, 9'd128, 16'sd0, {8'd200, 4'd1, 4'd2});
    // fade below zero in the slot A replacement
    add_voxel(OP_PAINT, 12'd9, 9'd511, 16'sd0, {8'd255, 4'd1, 4'd2});
    add_voxel(OP_PAINT, 12'd10, 9'd511, 16'sd0, {8'd250, 4'd7, 4'd5});
    add_voxel(OP_PAINT, 12'd11, 9'd511, 16'sd0, {8'd5, 4'd5, 4'd5});
    add_voxel(OP_PAINT, 12'd12, 9'd0, 16'sd0, 16'hffff);
    add_voxel(OP_PAINT, 12'd13, 9'd300, 16'sh8000, 16'h0000);
    add_voxel(OP_PAINT, 12'd4095, 9'd127, 16'sd0, {8'd127, 4'd0, 4'd0});
    add_voxel(OP_PAINT, 12'd0, 9'd256, 16'sd0, {8'd128, 4'd0, 4'd0});
    drain();

    // directed: most negative step, top texture, full strength
    apply_settings(16'sh8000, 4'd15, 16'hffff);
    add_voxel(OP_SCULPT, 12'd14, 9'd511, -16'sd32767, 16'h0000);
    add_voxel(OP_SCULPT, 12'd15, 9'd256, 16'sd0, 16'h0000);
    add_voxel(OP_PAINT, 12'd16, 9'd511, 16'sd0, 16'h00ff);
    add_voxel(OP_PAINT, 12'd17, 9'd511, 16'sd0, 16'h80f0);
    add_voxel(OP_SCULPT, 12'd18, 9'd255, 16'sd32767, 16'h0000);
    drain();

    // random phases across register settings
    apply_settings(16'($urandom), 4'($urandom), 16'($urandom));
    run_random(200);
    apply_settings(16'sd32767, 4'd15, 16'hffff);
    run_random(200);
    apply_settings(16'sh8000, 4'd0, 16'h0000);
    run_random(200);
    apply_settings(-16'sd32767, 4'($urandom), 16'h0100);
    run_random(200);
    apply_settings(16'($urandom), 4'($urandom), 16'($urandom_range(0, 1023)));
    run_random(150);
    apply_settings(16'($urandom), 4'($urandom), 16'($urandom));
    run_random(150);

    // last stretch with no idling on either side
    calm = 1'b1;
    apply_settings(16'($urandom), 4'($urandom), 16'($urandom));
    run_random(150);

    drain();
    $display("checked %0d results from %0d updates: %0d sculpt, %0d paint",
             results_checked, accepted_items, sculpt_items, paint_items);
    $display("%0d register settings incl. extremes, random idling and a long result hold",
             settings_used);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
